FILE: sv/sbmq_pkg.sv
`default_nettype none

package sbmq_pkg;

  localparam int NUM_ENTRIES = 64;
  localparam int NUM_QUEUES  = 4;
  localparam int IDX_W       = $clog2(NUM_ENTRIES);
  localparam int PTR_W       = $clog2(NUM_ENTRIES + 1);
  localparam int QID_W       = 2;
  localparam int QIDX_W      = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int DATA_W      = 32;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [IDX_W-1:0] idx_t;

  localparam ptr_t NULL_PTR = ptr_t'(NUM_ENTRIES);

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    op_t                      op;
    logic [QID_W-1:0]         queue_id;
    logic signed [DATA_W-1:0] data_in;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data_out;
    status_t                  status;
  } rsp_t;

  function automatic logic ptr_ok(input ptr_t p);
    return p < ptr_t'(NUM_ENTRIES);
  endfunction

endpackage

`default_nettype wire

FILE: sv/shared_buffer_multi_queue.sv
`default_nettype none

// Several FIFO queues share one 64-entry data store; entries are chained through
// a link memory and unused entries sit on a free list. Each request has a read
// step, in which the accept cycle reads the link and data memories (one
// registered read port each), and a write-back step in ST_EXEC. busy is high in
// ST_EXEC, and the result appears with done for one cycle right after it, so a
// new request may be issued in the same cycle in which done is shown. The
// receiver cannot stall results. No clearing pass is needed after reset.
module shared_buffer_multi_queue
  import sbmq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  wire req_t req,
  output logic      done,
  output rsp_t      rsp
);

  state_t state, state_next;

  ptr_t                     head_ptr [NUM_QUEUES];
  ptr_t                     tail_ptr [NUM_QUEUES];
  ptr_t                     free_head;
  logic [NUM_ENTRIES-1:0]   lvalid;

  logic [DATA_W-1:0]        entry_data [NUM_ENTRIES];
  ptr_t                     link_table [NUM_ENTRIES];

  logic                     accept;
  logic [QIDX_W-1:0]        qsel;
  logic                     q_ok;
  ptr_t                     cur_head;
  ptr_t                     cur_tail;
  ptr_t                     rd_ptr;
  logic                     fail;

  op_t                      op_r;
  logic [QIDX_W-1:0]        qsel_r;
  logic [DATA_W-1:0]        din_r;
  ptr_t                     ptr_r;
  ptr_t                     tail_r;
  logic                     fail_r;
  logic                     last_r;
  logic                     empty_r;

  ptr_t                     link_rd;
  logic [DATA_W-1:0]        data_rd;
  logic                     lv_rd;
  ptr_t                     link_eff;

  logic                     exec_ok;
  logic                     lw_en;
  idx_t                     lw_addr;
  ptr_t                     lw_data;
  logic                     dw_en;

  assign accept   = start && !busy;
  assign qsel     = req.queue_id[QIDX_W-1:0];
  assign q_ok     = (QID_W + 1)'(req.queue_id) < (QID_W + 1)'(NUM_QUEUES);
  assign cur_head = head_ptr[qsel];
  assign cur_tail = tail_ptr[qsel];
  assign rd_ptr   = (req.op == OP_DEQ) ? cur_head : free_head;
  assign fail     = !q_ok || !ptr_ok(rd_ptr);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_EXEC;
      ST_EXEC: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy = 1'b0;
    unique case (state)
      ST_IDLE: busy = 1'b0;
      ST_EXEC: busy = 1'b1;
      default: busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= req.op;
      qsel_r  <= qsel;
      din_r   <= req.data_in;
      ptr_r   <= rd_ptr;
      tail_r  <= cur_tail;
      fail_r  <= fail;
      last_r  <= (cur_head == cur_tail);
      empty_r <= !ptr_ok(cur_head);
      lv_rd   <= lvalid[rd_ptr[IDX_W-1:0]];
    end
  end

  // memory read port
  always_ff @(posedge clk) begin
    if (accept) begin
      link_rd <= link_table[rd_ptr[IDX_W-1:0]];
      data_rd <= entry_data[rd_ptr[IDX_W-1:0]];
    end
  end

  // unwritten link entries read as their reset chain
  always_comb begin
    if (lv_rd) begin
      link_eff = link_rd;
    end else if (ptr_r[IDX_W-1:0] == idx_t'(NUM_ENTRIES - 1)) begin
      link_eff = NULL_PTR;
    end else begin
      link_eff = ptr_t'(ptr_r + 1'b1);
    end
  end

  assign exec_ok = (state == ST_EXEC) && !fail_r;

  always_comb begin
    lw_en   = 1'b0;
    lw_addr = ptr_r[IDX_W-1:0];
    lw_data = free_head;
    dw_en   = 1'b0;
    if (exec_ok) begin
      if (op_r == OP_ENQ) begin
        dw_en   = 1'b1;
        lw_en   = !empty_r;
        lw_addr = tail_r[IDX_W-1:0];
        lw_data = ptr_r;
      end else begin
        lw_en   = 1'b1;
        lw_addr = ptr_r[IDX_W-1:0];
        lw_data = free_head;
      end
    end
  end

  // memory write port
  always_ff @(posedge clk) begin
    if (lw_en) begin
      link_table[lw_addr] <= lw_data;
    end
    if (dw_en) begin
      entry_data[ptr_r[IDX_W-1:0]] <= din_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      free_head <= '0;
      lvalid    <= '0;
      done      <= 1'b0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_ptr[i] <= NULL_PTR;
      end
    end else begin
      state <= state_next;
      done  <= (state == ST_EXEC);
      if (lw_en) begin
        lvalid[lw_addr] <= 1'b1;
      end
      if (exec_ok) begin
        if (op_r == OP_ENQ) begin
          free_head <= link_eff;
          if (empty_r) begin
            head_ptr[qsel_r] <= ptr_r;
          end
        end else begin
          head_ptr[qsel_r] <= last_r ? NULL_PTR : link_eff;
          free_head        <= ptr_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec_ok && (op_r == OP_ENQ)) begin
      tail_ptr[qsel_r] <= ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      rsp.data_out <= (op_r == OP_DEQ && !fail_r) ? data_rd : '0;
      if (!fail_r) begin
        rsp.status <= STAT_OK;
      end else if (op_r == OP_DEQ) begin
        rsp.status <= STAT_EMPTY;
      end else begin
        rsp.status <= STAT_FULL;
      end
    end
  end

  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_EXEC))
    else $error("done without a preceding execute cycle");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_EXEC))
    else $error("accepted request did not enter execute");

  a_exec_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC) |=> (state == ST_IDLE) && done)
    else $error("execute did not complete in one cycle");

  a_fail_zero_data: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status != STAT_OK) |-> (rsp.data_out == '0))
    else $error("failed request returned nonzero data");

endmodule

`default_nettype wire
